>>> rtl/blqr_pkg.sv
// ----------------------------------------------------------------------------
// blqr_pkg: shared types and constants for the LQR balance controller
// Fixed-point formats, multiplier request/response types, CORDIC angle table
// and the reciprocal constants used for the divisions by constants.
// ----------------------------------------------------------------------------
package blqr_pkg;

    // Fraction bits of gains, torque, rate and velocity
    localparam int FRACTION_BITS    = 12;
    localparam int CORDIC_STEPS_DEF = 16;

    // Stream and config widths
    localparam int IN_W       = 64;
    localparam int OUT_W      = 128;
    localparam int GAIN_W     = 24;
    localparam int CFG_ADDR_W = 2;

    // Config register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_POSITION = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_VELOCITY = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_ANGLE    = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_RATE     = CFG_ADDR_W'(3);

    // Shared multiplier: signed A x signed B, full product
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 31;
    localparam int MUL_P_W = 64;

    // CORDIC datapath: X/Y hold 2^16-scaled samples times the CORDIC gain,
    // Z holds Q30 radians
    localparam int CORDIC_W    = 36;
    localparam int ANGLE_W     = 34;
    localparam int ATAN_LEN    = 24;
    localparam int ATAN_IDX_W  = 5;
    localparam int ATAN_W      = 31;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // Meters per encoder pulse, Q32
    localparam int MPP_Q32 = 313567;
    localparam int VEL_MUL = MPP_Q32 * 10;
    localparam int POS_SHIFT = 16;
    localparam int VEL_SHIFT = 32 - FRACTION_BITS;

    // Accumulator is Q(F+16)
    localparam int ACC_W       = 60;
    localparam int VEL_ALIGN   = 16 - FRACTION_BITS;
    localparam int ANGLE_ALIGN = 3;

    // Rate: round(|gyro| * 2^F / 131) = floor(N / 262), N = |gyro|*2^(F+1) + 131.
    // Reciprocal multiply is exact while N * error < 2^RATE_K.
    localparam int RATE_DIV = 262;
    localparam int RATE_NW  = 17 + FRACTION_BITS;
    localparam int RATE_K   = RATE_NW + 9;
    localparam longint RATE_M = ((64'sd1 <<< RATE_K) + RATE_DIV - 1) / RATE_DIV;
    localparam int RATE_W   = 21;

    // Duty: floor(mag * 25500 / (353 * 2^F))
    //     = floor(floor(mag * 6375 / 2^(F-2)) / 353), for mag below saturation
    localparam int DUTY_NUM     = 6375;
    localparam int DUTY_DIV     = 353;
    localparam int DUTY_SHIFT   = FRACTION_BITS - 2;
    localparam int DUTY_MAG_SAT =
        (255 * DUTY_DIV * (1 << FRACTION_BITS) + 25500 - 1) / 25500;
    localparam int DUTY_MAG_W   = $clog2(DUTY_MAG_SAT);
    localparam int DUTY_PW      = 17;
    localparam int DUTY_K       = 26;
    localparam longint DUTY_M   = ((64'sd1 <<< DUTY_K) + DUTY_DIV - 1) / DUTY_DIV;

    typedef enum logic [3:0] {
        MOP_RATE,
        MOP_POS,
        MOP_VEL,
        MOP_GP,
        MOP_GV,
        MOP_GR,
        MOP_GA,
        MOP_DUTY1,
        MOP_DUTY2
    } mop_t;

    typedef struct packed {
        logic                      valid;
        mop_t                      op;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                      valid;
        mop_t                      op;
        logic signed [MUL_P_W-1:0] p;
    } mul_rsp_t;

    // atan(2^-i) in Q30
    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = ATAN_W'(843314857);
            5'd1:    v = ATAN_W'(497837830);
            5'd2:    v = ATAN_W'(263043837);
            5'd3:    v = ATAN_W'(133525159);
            5'd4:    v = ATAN_W'(67021687);
            5'd5:    v = ATAN_W'(33543516);
            5'd6:    v = ATAN_W'(16775851);
            5'd7:    v = ATAN_W'(8388437);
            5'd8:    v = ATAN_W'(4194283);
            5'd9:    v = ATAN_W'(2097149);
            5'd10:   v = ATAN_W'(1048576);
            5'd11:   v = ATAN_W'(524288);
            5'd12:   v = ATAN_W'(262144);
            5'd13:   v = ATAN_W'(131072);
            5'd14:   v = ATAN_W'(65536);
            5'd15:   v = ATAN_W'(32768);
            5'd16:   v = ATAN_W'(16384);
            5'd17:   v = ATAN_W'(8192);
            5'd18:   v = ATAN_W'(4096);
            5'd19:   v = ATAN_W'(2048);
            5'd20:   v = ATAN_W'(1024);
            5'd21:   v = ATAN_W'(512);
            5'd22:   v = ATAN_W'(256);
            5'd23:   v = ATAN_W'(128);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/balance_lqr_state_feedback.sv
// ----------------------------------------------------------------------------
// balance_lqr_state_feedback: LQR state feedback for a two-wheeled balancer
// Tilt by CORDIC, rate, wheel position and velocity, four-gain torque and
// a saturated PWM duty with direction, one result word per sample word.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload (lowest bit up)
//  -------  ---  -----------------  ------------------------------------------
//  s_*      in   s_tvalid/s_tready  accel_x, accel_z, gyro_x, pulse_count
//  m_*      out  m_tvalid/m_tready  drive_torque, pwm_duty, drive_forward,
//                                   tilt_angle, tilt_rate, wheel_position,
//                                   wheel_velocity
//  cfg_*    in   cfg_we             gain_position, gain_velocity, gain_angle,
//                                   gain_rate (index 0..3)
//
//  The CORDIC loop, one step per cycle, sets how long a word takes from
//  acceptance back to ready; the six products of the shared multiplier
//  overlap with it, the two duty products follow it. s_tready is high only
//  while the sequencer waits for a word.
//  The result word sits in an output register; a stalled m_tready holds the
//  sequencer in its last state and the result stays put.
//  Reset clears the control state, loads the default gains and clears the
//  running pulse total.
//
// ----------------------------------------------------------------------------
module balance_lqr_state_feedback
    import blqr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x[15:0], accel_z[31:16], gyro_x[47:32], pulse_count[63:48]
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive_torque[31:0], pwm_duty[39:32], drive_forward[40],
    // tilt_angle[56:41], tilt_rate[77:57], wheel_position[109:78],
    // wheel_velocity[127:110]
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]     cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE,
        ST_POS,
        ST_VEL,
        ST_GP,
        ST_GV,
        ST_GR,
        ST_GA,
        ST_TORQ,
        ST_MAG,
        ST_DUTY1,
        ST_DUTY2,
        ST_OUT
    } state_t;

    localparam logic signed [MUL_P_W-1:0] POS_HALF = MUL_P_W'(1 << (POS_SHIFT - 1));
    localparam logic signed [MUL_P_W-1:0] VEL_HALF = MUL_P_W'(1 << (VEL_SHIFT - 1));
    localparam logic signed [MUL_P_W-1:0] P_S32_MAX = MUL_P_W'(32'h7FFF_FFFF);
    localparam logic signed [MUL_P_W-1:0] P_S32_MIN = ~P_S32_MAX;
    localparam logic signed [MUL_P_W-1:0] P_S18_MAX = MUL_P_W'(18'h1FFFF);
    localparam logic signed [MUL_P_W-1:0] P_S18_MIN = ~P_S18_MAX;
    localparam logic signed [ACC_W-1:0]   ACC_HALF = ACC_W'(1 << 15);
    localparam logic signed [ACC_W-1:0]   A_S32_MAX = ACC_W'(32'h7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]   A_S32_MIN = ~A_S32_MAX;
    localparam logic signed [32:0]        PT_MAX = 33'sh0_7FFF_FFFF;
    localparam logic signed [32:0]        PT_MIN = ~PT_MAX;

    state_t                     state_reg;
    state_t                     state_next;

    logic signed [GAIN_W-1:0]   gain_position_reg;
    logic signed [GAIN_W-1:0]   gain_velocity_reg;
    logic signed [GAIN_W-1:0]   gain_angle_reg;
    logic signed [GAIN_W-1:0]   gain_rate_reg;

    logic signed [15:0]         gx_reg;
    logic signed [15:0]         pc_reg;
    logic signed [31:0]         pt_reg;
    logic signed [RATE_W-1:0]   rate_reg;
    logic signed [31:0]         pos_reg;
    logic signed [17:0]         vel_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [31:0]         torque_reg;

    logic                       m_tvalid_reg;
    logic [OUT_W-1:0]           m_tdata_reg;

    logic                       accept;
    logic                       out_free;
    logic signed [15:0]         in_ax, in_az, in_gx, in_pc;
    logic signed [32:0]         pt_sum;
    logic signed [31:0]         pt_sat;

    logic                       tilt_done;
    logic signed [15:0]         tilt_angle;

    mul_req_t                   mul_req;
    mul_rsp_t                   mul_rsp;

    logic [15:0]                gx_abs;
    logic [RATE_NW-1:0]         rate_num;
    logic [RATE_W-1:0]          rate_q;
    logic signed [RATE_W-1:0]   rate_val;
    logic signed [MUL_P_W-1:0]  pos_rnd;
    logic signed [31:0]         pos_val;
    logic signed [MUL_P_W-1:0]  vel_rnd;
    logic signed [17:0]         vel_val;
    logic signed [ACC_W-1:0]    prod_acc;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [31:0]         torque_val;
    logic [31:0]                mag;
    logic                       duty_over;
    logic [7:0]                 pwm_duty;
    logic                       drive_forward;

    assign in_ax = s_tdata[15:0];
    assign in_az = s_tdata[31:16];
    assign in_gx = s_tdata[47:32];
    assign in_pc = s_tdata[63:48];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Running pulse total, clamped at the 32-bit limits
    assign pt_sum = 33'(pt_reg) + 33'(in_pc);
    assign pt_sat = (pt_sum > PT_MAX) ? PT_MAX[31:0] :
                    (pt_sum < PT_MIN) ? PT_MIN[31:0] : pt_sum[31:0];

    blqr_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .accel_x (in_ax),
        .accel_z (in_az),
        .done    (tilt_done),
        .angle   (tilt_angle)
    );

    blqr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Rate numerator: 2 * |gyro| * 2^F + 131, rounds |gyro| * 2^F / 131 half up
    assign gx_abs   = gx_reg[15] ? 16'(-gx_reg) : 16'(gx_reg);
    assign rate_num = RATE_NW'({gx_abs, (FRACTION_BITS + 1)'(0)}) + RATE_NW'(131);

    // Torque magnitude and duty saturation
    assign mag       = torque_reg[31] ? 32'(-torque_reg) : 32'(torque_reg);
    assign duty_over = (mag >= 32'(DUTY_MAG_SAT));

    // Issue at most one product per sequencer step
    always_comb
    begin
        mul_req.valid = 1'b0;
        mul_req.op    = MOP_RATE;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (state_reg)
            ST_RATE:
            begin
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_RATE;
                mul_req.a     = MUL_A_W'(rate_num);
                mul_req.b     = MUL_B_W'(RATE_M);
            end
            ST_POS:
            begin
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_POS;
                mul_req.a     = MUL_A_W'(pt_reg);
                mul_req.b     = MUL_B_W'(MPP_Q32);
            end
            ST_VEL:
            begin
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_VEL;
                mul_req.a     = MUL_A_W'(pc_reg);
                mul_req.b     = MUL_B_W'(VEL_MUL);
            end
            ST_GP:
            begin
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_GP;
                mul_req.a     = MUL_A_W'(pos_reg);
                mul_req.b     = MUL_B_W'(gain_position_reg);
            end
            ST_GV:
            begin
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_GV;
                mul_req.a     = MUL_A_W'(vel_reg);
                mul_req.b     = MUL_B_W'(gain_velocity_reg);
            end
            ST_GR:
            begin
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_GR;
                mul_req.a     = MUL_A_W'(rate_reg);
                mul_req.b     = MUL_B_W'(gain_rate_reg);
            end
            ST_GA:
            begin
                // wait here for the CORDIC
                mul_req.valid = tilt_done;
                mul_req.op    = MOP_GA;
                mul_req.a     = MUL_A_W'(tilt_angle);
                mul_req.b     = MUL_B_W'(gain_angle_reg);
            end
            ST_DUTY1:
            begin
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_DUTY1;
                mul_req.a     = MUL_A_W'(mag[DUTY_MAG_W-1:0]);
                mul_req.b     = MUL_B_W'(DUTY_NUM);
            end
            ST_DUTY2:
            begin
                // divide the scaled magnitude by 353 through its reciprocal
                mul_req.valid = 1'b1;
                mul_req.op    = MOP_DUTY2;
                mul_req.a     = MUL_A_W'(mul_rsp.p[DUTY_SHIFT +: DUTY_PW]);
                mul_req.b     = MUL_B_W'(DUTY_M);
            end
            default:
            begin
                mul_req.valid = 1'b0;
            end
        endcase
    end

    // Post-processing of returned products
    // Quotient stays below 2^20 over the whole gyro range, so no clamp
    assign rate_q   = mul_rsp.p[RATE_K +: RATE_W];
    assign rate_val = gx_reg[15] ? -$signed(rate_q) : $signed(rate_q);

    assign pos_rnd = (mul_rsp.p + POS_HALF) >>> POS_SHIFT;
    assign pos_val = (pos_rnd > P_S32_MAX) ? P_S32_MAX[31:0] :
                     (pos_rnd < P_S32_MIN) ? P_S32_MIN[31:0] : pos_rnd[31:0];

    assign vel_rnd = (mul_rsp.p + VEL_HALF) >>> VEL_SHIFT;
    assign vel_val = (vel_rnd > P_S18_MAX) ? P_S18_MAX[17:0] :
                     (vel_rnd < P_S18_MIN) ? P_S18_MIN[17:0] : vel_rnd[17:0];

    assign prod_acc = mul_rsp.p[ACC_W-1:0];

    assign acc_rnd    = (acc_reg + ACC_HALF) >>> 16;
    assign torque_val = (acc_rnd > A_S32_MAX) ? A_S32_MAX[31:0] :
                        (acc_rnd < A_S32_MIN) ? A_S32_MIN[31:0] : acc_rnd[31:0];

    assign pwm_duty      = duty_over ? 8'd255 : mul_rsp.p[DUTY_K +: 8];
    assign drive_forward = !torque_reg[31] && (torque_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_RATE;
            ST_RATE:  state_next = ST_POS;
            ST_POS:   state_next = ST_VEL;
            ST_VEL:   state_next = ST_GP;
            ST_GP:    state_next = ST_GV;
            ST_GV:    state_next = ST_GR;
            ST_GR:    state_next = ST_GA;
            ST_GA:    if (tilt_done) state_next = ST_TORQ;
            ST_TORQ:  state_next = ST_MAG;
            ST_MAG:   state_next = ST_DUTY1;
            ST_DUTY1: state_next = ST_DUTY2;
            ST_DUTY2: state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer state, datapath registers and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pt_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                gx_reg <= in_gx;
                pc_reg <= in_pc;
                pt_reg <= pt_sat;
            end

            if (mul_rsp.valid)
            begin
                case (mul_rsp.op) inside
                    MOP_RATE:       rate_reg <= rate_val;
                    MOP_POS:        pos_reg  <= pos_val;
                    MOP_VEL:        vel_reg  <= vel_val;
                    MOP_GP:         acc_reg  <= prod_acc;
                    MOP_GV, MOP_GR: acc_reg  <= acc_reg + (prod_acc <<< VEL_ALIGN);
                    MOP_GA:         acc_reg  <= acc_reg + (prod_acc <<< ANGLE_ALIGN);
                    default:        ;
                endcase
            end

            if (state_reg == ST_MAG)
            begin
                torque_reg <= torque_val;
            end

            // Load the result word once the output register is free
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {vel_reg, pos_reg, rate_reg, tilt_angle,
                                 drive_forward, pwm_duty, torque_reg};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_position_reg <= GAIN_W'(-4096);
            gain_velocity_reg <= GAIN_W'(-12440);
            gain_angle_reg    <= GAIN_W'(-285794);
            gain_rate_reg     <= GAIN_W'(-56701);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN_POSITION: gain_position_reg <= cfg_wdata;
                REG_GAIN_VELOCITY: gain_velocity_reg <= cfg_wdata;
                REG_GAIN_ANGLE:    gain_angle_reg    <= cfg_wdata;
                REG_GAIN_RATE:     gain_rate_reg     <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A sample word is taken only once per pass through the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    // Products only come back while a sample is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.valid |-> (state_reg != ST_IDLE))
        else $error("multiplier result with no sample in work");

    // The tilt angle is final before the result word is formed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> tilt_done)
        else $error("result formed before the CORDIC finished");

    // Forward drive only for a positive torque
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && out_free) |=> (!m_tdata[40] || !m_tdata[31]))
        else $error("forward flag set for a negative torque");

endmodule

>>> rtl/blqr_mul.sv
// ----------------------------------------------------------------------------
// blqr_mul: shared signed multiplier
// One product per request, registered, returned in the next cycle with its tag.
// ----------------------------------------------------------------------------
module blqr_mul
    import blqr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                      valid_reg;
    mop_t                      op_reg;
    logic signed [MUL_P_W-1:0] p_reg;
    logic signed [MUL_P_W-1:0] prod;

    assign prod = req.a * req.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= req.valid;
        end
    end

    // Hold the product until the next request
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            op_reg <= req.op;
            p_reg  <= prod;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.op    = op_reg;
    assign rsp.p     = p_reg;

endmodule

>>> rtl/blqr_cordic.sv
// ----------------------------------------------------------------------------
// blqr_cordic: iterative vectoring CORDIC for the tilt angle
// Computes atan2(-accel_x, accel_z) in Q13 radians, one step per cycle.
// ----------------------------------------------------------------------------
module blqr_cordic
    import blqr_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_z,
    output logic               done,
    output logic signed [15:0] angle
);

    localparam int SW = $clog2(STEPS);
    localparam int Z_SHIFT = 17;
    localparam logic signed [ANGLE_W-1:0] Z_HALF  = ANGLE_W'(65536);
    localparam logic signed [ANGLE_W-1:0] HALF_PI = ANGLE_W'(HALF_PI_Q30);
    localparam logic signed [ANGLE_W-1:0] ANG_MAX = ANGLE_W'(32767);
    localparam logic signed [ANGLE_W-1:0] ANG_MIN = ~ANG_MAX;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_RUN,
        CS_ROUND
    } cstate_t;

    cstate_t                    state_reg;
    logic        [SW-1:0]       step_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ANGLE_W-1:0]  z_reg;
    logic                       zero_reg;
    logic                       done_reg;
    logic signed [15:0]         angle_reg;

    logic signed [CORDIC_W-1:0] x0, y0, xi, yi;
    logic signed [ANGLE_W-1:0]  zi;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  at_step;
    logic signed [ANGLE_W-1:0]  z_sh;
    logic signed [15:0]         angle_sat;

    // Scale by 2^16, pre-rotate into the right half plane
    always_comb
    begin
        x0 = {{(CORDIC_W-32){accel_z[15]}}, accel_z, 16'd0};
        y0 = -{{(CORDIC_W-32){accel_x[15]}}, accel_x, 16'd0};
        xi = x0;
        yi = y0;
        zi = '0;
        if (x0[CORDIC_W-1])
        begin
            if (!y0[CORDIC_W-1])
            begin
                xi = y0;
                yi = -x0;
                zi = HALF_PI;
            end
            else
            begin
                xi = -y0;
                yi = x0;
                zi = -HALF_PI;
            end
        end
    end

    assign dx      = y_reg >>> step_reg;
    assign dy      = x_reg >>> step_reg;
    assign at_step = ANGLE_W'(atan_q30(ATAN_IDX_W'(step_reg)));

    // Round Q30 to Q13 half up, then clamp to 16 bits
    assign z_sh = (z_reg + Z_HALF) >>> Z_SHIFT;
    assign angle_sat = (z_sh > ANG_MAX) ? ANG_MAX[15:0] :
                       (z_sh < ANG_MIN) ? ANG_MIN[15:0] : z_sh[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                CS_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= xi;
                        y_reg     <= yi;
                        z_reg     <= zi;
                        zero_reg  <= (accel_x == '0) && (accel_z == '0);
                        step_reg  <= '0;
                        done_reg  <= 1'b0;
                        state_reg <= CS_RUN;
                    end
                end
                CS_RUN:
                begin
                    if (!y_reg[CORDIC_W-1])
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at_step;
                    end
                    else
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at_step;
                    end
                    if (step_reg == SW'(STEPS - 1))
                    begin
                        state_reg <= CS_ROUND;
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                    end
                end
                CS_ROUND:
                begin
                    angle_reg <= zero_reg ? '0 : angle_sat;
                    done_reg  <= 1'b1;
                    state_reg <= CS_IDLE;
                end
                default:
                begin
                    state_reg <= CS_IDLE;
                end
            endcase
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule
